/* src/sd_host_clock_divisor_select_unit_macros.svh */
// Assertion helpers for the divisor select unit.
`ifndef SD_HOST_CLOCK_DIVISOR_SELECT_UNIT_MACROS_SVH
`define SD_HOST_CLOCK_DIVISOR_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define SDCDS_ASSERT_NOW(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define SDCDS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

/* src/sdcds_pkg.sv */
package sdcds_pkg;

  localparam int DATA_W     = 32;
  localparam int FIELD_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEPS  = 32;

  localparam int MAX_DIV_V3_DEF     = 2046;
  localparam int MAX_DIV_V2_DEF     = 256;
  localparam int PROG_DIV_LIMIT_DEF = 1024;

  localparam logic [DATA_W-1:0]  BASE_CLOCK_RST = 32'd200000000;
  localparam logic [DATA_W-1:0]  HS_THRESHOLD   = 32'd26000000;
  localparam logic [FIELD_W-1:0] FIELD_MAX      = 10'd1023;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_CLOCK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_V3    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_MODE  = 2'd2;

  // smallest power of two not below n
  function automatic int pow2_ceil(input int n);
    int p;
    p = 1;
    while (p < n) p = p * 2;
    return p;
  endfunction

endpackage

/* src/sd_host_clock_divisor_select_unit.sv */
// SD host card clock divisor select.
// Configuration: cfg_valid/cfg_ready write channel (cfg_ready always high),
// cfg_index 0 = base clock in Hz, 1 = spec 3.00 flag, 2 = programmable mode.
// Other indexes are ignored. Write only while busy is low.
// Requests: an item is taken when start is high and busy is low; target_hz
// is the wanted card clock. busy stays high until the result is shown.
// Result: done strobes for one cycle with divisor_field, generator_select,
// high_speed and clamped; the receiver cannot stall, so nothing is held.
// Operation: after the accepting edge the sequencer runs 32 steps of a
// restoring radix-2 divider computing base / (target + 1), then a finish step
// maps the quotient onto the mode's divisor set and registers it with done.
// A new item can be started in the cycle done is high.
// Reset (rst, synchronous): registers return to 200 MHz base, spec 3.00,
// divided mode; the sequencer goes idle and any item in flight is dropped.
module sd_host_clock_divisor_select_unit #(
  parameter int MAX_DIV_V3     = sdcds_pkg::MAX_DIV_V3_DEF,
  parameter int MAX_DIV_V2     = sdcds_pkg::MAX_DIV_V2_DEF,
  parameter int PROG_DIV_LIMIT = sdcds_pkg::PROG_DIV_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sdcds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdcds_pkg::DATA_W-1:0]       cfg_data,
  input  logic                               start,
  output logic                               busy,
  input  logic [sdcds_pkg::DATA_W-1:0]       target_hz,
  output logic                               done,
  output logic [sdcds_pkg::FIELD_W-1:0]      divisor_field,
  output logic                               generator_select,
  output logic                               high_speed,
  output logic                               clamped
);
  import sdcds_pkg::*;

  `include "sd_host_clock_divisor_select_unit_macros.svh"

  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int V3_HALF   = (MAX_DIV_V3 + 1) / 2;
  localparam int V2_STOP   = pow2_ceil(MAX_DIV_V2);
  localparam int V2_K      = $clog2(V2_STOP);
  localparam int V2_W      = V2_K + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FINISH} state_t;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   quo;
  logic [DATA_W:0]     dvs;
  logic                hs;

  logic [DATA_W-1:0]   base_clock_hz;
  logic                spec_v3;
  logic                programmable_mode;

  logic [DATA_W:0]     rem_sh;
  logic                q_bit;
  logic [DATA_W-1:0]   rem_next;

  logic [DATA_W-1:0]   prog_f;
  logic [FIELD_W-1:0]  prog_field;
  logic                prog_clamp;
  logic [DATA_W-1:0]   v3_half_q;
  logic [FIELD_W-1:0]  v3_field;
  logic [V2_W-1:0]     v2_div;
  logic [FIELD_W-1:0]  v2_field;
  logic [FIELD_W-1:0]  field_next;
  logic                clamp_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // one restoring divider step
  always_comb begin
    rem_sh = {rem, quo[DATA_W-1]};
    q_bit  = (rem_sh >= dvs);
    if (q_bit) rem_next = DATA_W'(rem_sh - dvs);
    else       rem_next = rem_sh[DATA_W-1:0];
  end

  // quotient q = base / (target + 1); smallest fitting divisor is q + 1
  always_comb begin
    prog_f = (quo > DATA_W'(PROG_DIV_LIMIT)) ? DATA_W'(PROG_DIV_LIMIT) : quo;
    if (prog_f > DATA_W'(FIELD_MAX)) begin
      prog_field = FIELD_MAX;
      prog_clamp = 1'b1;
    end else begin
      prog_field = prog_f[FIELD_W-1:0];
      prog_clamp = 1'b0;
    end

    // smallest even divisor above q, halved, capped at the stop value
    v3_half_q = {1'b0, quo[DATA_W-1:1]} + DATA_W'(1);
    if (quo == '0)                             v3_field = '0;
    else if (v3_half_q > DATA_W'(V3_HALF))     v3_field = FIELD_W'(V3_HALF);
    else                                       v3_field = v3_half_q[FIELD_W-1:0];

    // smallest power of two above q, capped at the stop value
    v2_div = V2_W'(V2_STOP);
    if (quo < DATA_W'(V2_STOP)) begin
      for (int k = V2_K; k >= 0; k--) begin
        if (DATA_W'(1 << k) > quo) v2_div = V2_W'(1 << k);
      end
    end
    v2_field = FIELD_W'(v2_div >> 1);

    clamp_next = 1'b0;
    if (spec_v3 && programmable_mode) begin
      field_next = prog_field;
      clamp_next = prog_clamp;
    end else if (spec_v3) begin
      field_next = v3_field;
    end else begin
      field_next = v2_field;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_hz     <= BASE_CLOCK_RST;
      spec_v3           <= 1'b1;
      programmable_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_CLOCK: base_clock_hz     <= cfg_data;
        CFG_SPEC_V3:    spec_v3           <= cfg_data[0];
        CFG_PROG_MODE:  programmable_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rem   <= '0;
            quo   <= base_clock_hz;
            dvs   <= {1'b0, target_hz} + (DATA_W+1)'(1);
            hs    <= (target_hz > HS_THRESHOLD);
            cnt   <= CNT_W'(DIV_STEPS - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          quo <= {quo[DATA_W-2:0], q_bit};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) state <= ST_FINISH;
        end
        ST_FINISH: begin
          divisor_field    <= field_next;
          generator_select <= spec_v3 && programmable_mode;
          high_speed       <= hs;
          clamped          <= clamp_next;
          done             <= 1'b1;
          state            <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SDCDS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy,
    "accepted item did not raise busy")
  `SDCDS_ASSERT_NEXT(a_finish_done, clk, rst, state == ST_FINISH, done && !busy,
    "finish step did not deliver a result")
  `SDCDS_ASSERT_NOW(a_clamp_mode, clk, rst, done && clamped,
    generator_select && divisor_field == FIELD_MAX,
    "clamp outside programmable mode or field not saturated")
  `SDCDS_ASSERT_NOW(a_done_idle, clk, rst, done, state == ST_IDLE,
    "result strobe while sequencer active")

endmodule

/* verif/sd_clock_divisor_checker.sv */
`timescale 1ns / 1ps

// Watches the register channel, the request handshake and the done strobe.
// Keeps its own copy of the clock registers, works out the select value for
// each accepted item and compares it with what comes out.
module sd_clock_divisor_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sdcds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdcds_pkg::DATA_W-1:0]    cfg_data,
  input  logic                            start,
  input  logic                            busy,
  input  logic [sdcds_pkg::DATA_W-1:0]    target_hz,
  input  logic                            done,
  input  logic [sdcds_pkg::FIELD_W-1:0]   divisor_field,
  input  logic                            generator_select,
  input  logic                            high_speed,
  input  logic                            clamped,
  output int                              errors,
  output int                              pending,
  output int                              checked,
  output int                              clamp_hits
);
  import sdcds_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] field;
    logic               gen;
    logic               hs;
    logic               clamp;
  } clk_select_t;

  logic [DATA_W-1:0] base_hz;
  logic              v3_host;
  logic              prog_gen;
  clk_select_t       awaited_selects[$];

  function automatic clk_select_t divisor_choice(input logic [DATA_W-1:0] base,
                                                 input logic v3, input logic prog,
                                                 input logic [DATA_W-1:0] tgt);
    clk_select_t r;
    int unsigned d;
    r = '0;
    r.hs = (tgt > HS_THRESHOLD);
    if (v3) begin
      if (prog) begin
        d = 1;
        while (d <= PROG_DIV_LIMIT_DEF && base / d > tgt) d++;
        // nothing fits: divisor would be one past the limit, field saturates
        if (d - 1 > FIELD_MAX) begin
          r.field = FIELD_MAX;
          r.clamp = 1'b1;
        end else begin
          r.field = FIELD_W'(d - 1);
        end
        r.gen = 1'b1;
      end else begin
        if (base <= tgt) begin
          d = 1;
        end else begin
          d = 2;
          while (d < MAX_DIV_V3_DEF && base / d > tgt) d += 2;
        end
        r.field = FIELD_W'(d >> 1);
      end
    end else begin
      // programmable flag has no effect without a v3 host
      d = 1;
      while (d < MAX_DIV_V2_DEF && base / d > tgt) d *= 2;
      r.field = FIELD_W'(d >> 1);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    clk_select_t seen, want;
    if (rst) begin
      base_hz  <= BASE_CLOCK_RST;
      v3_host  <= 1'b1;
      prog_gen <= 1'b0;
      awaited_selects.delete();
      pending  <= 0;
    end else begin
      if (done) begin
        seen = '{divisor_field, generator_select, high_speed, clamped};
        if (awaited_selects.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with nothing awaited: field=%0d gen=%0b hs=%0b clamp=%0b",
                     $time, seen.field, seen.gen, seen.hs, seen.clamp);
          errors <= errors + 1;
        end else begin
          want = awaited_selects.pop_front();
          checked <= checked + 1;
          if (want.clamp) clamp_hits <= clamp_hits + 1;
          if (seen !== want) begin
            if (errors < 10)
              $display({"%0t: mismatch: expected field=%0d gen=%0b hs=%0b clamp=%0b,",
                        " got field=%0d gen=%0b hs=%0b clamp=%0b"}, $time,
                       want.field, want.gen, want.hs, want.clamp,
                       seen.field, seen.gen, seen.hs, seen.clamp);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy)
        awaited_selects.push_back(divisor_choice(base_hz, v3_host, prog_gen, target_hz));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_CLOCK: base_hz  <= cfg_data;
          CFG_SPEC_V3:    v3_host  <= cfg_data[0];
          CFG_PROG_MODE:  prog_gen <= cfg_data[0];
          default: ;
        endcase
      end
      pending <= awaited_selects.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sdcds_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 78;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 start = 1'b0;
  logic [DATA_W-1:0]    target_hz = '0;
  logic                 cfg_ready, busy, done;
  logic [FIELD_W-1:0]   divisor_field;
  logic                 generator_select, high_speed, clamped;

  int errors, pending, checked, clamp_hits;
  int cycles = 0;
  int sent = 0;
  int settings = 1;
  int calm_left = 0;
  logic [DATA_W-1:0] base_now = BASE_CLOCK_RST;

  // reset setting: v3 divided mode at 200 MHz
  logic [DATA_W-1:0] div3_targets[] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd26000000,
                                        32'd26000001, 32'd200000000, 32'd199999999,
                                        32'd100000000, 32'd97751, 32'd97750};
  logic [DATA_W-1:0] prog_targets[] = '{32'd0, 32'd195312, 32'd200000000, 32'd1000000};
  logic [DATA_W-1:0] pow2_targets[] = '{32'd0, 32'd781250, 32'd100000000, 32'hFFFF_FFFF};
  logic [DATA_W-1:0] zero_targets[] = '{32'd0, 32'd5};

  sd_host_clock_divisor_select_unit dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .start, .busy,
    .target_hz, .done, .divisor_field, .generator_select, .high_speed, .clamped
  );

  sd_clock_divisor_checker chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .start, .busy,
    .target_hz, .done, .divisor_field, .generator_select, .high_speed, .clamped,
    .errors, .pending, .checked, .clamp_hits
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped at cycle limit with %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, some long, and now and then a stretch with none
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 5) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(60, 150);
  endfunction

  // targets clustered on divisor edges so the search ends at varied points
  function automatic logic [DATA_W-1:0] random_target(input logic [DATA_W-1:0] base);
    int unsigned d;
    logic [DATA_W-1:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2100) : $urandom_range(1, 300);
        t = base / d + $urandom_range(0, 4) - 2;
      end
      3, 4: begin
        d = 1 << $urandom_range(0, 11);
        t = base / d + $urandom_range(0, 2) - 1;
      end
      5, 6: t = $urandom;
      7:    t = $urandom_range(0, 300);
      8:    t = HS_THRESHOLD + $urandom_range(0, 4) - 2;
      default: begin
        case ($urandom_range(0, 3))
          0:       t = '0;
          1:       t = '1;
          2:       t = base;
          default: t = base - 1;
        endcase
      end
    endcase
    return t;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat (1 + $urandom_range(0, 3)) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] base, input logic v3, input logic prog);
    logic [DATA_W-1:0] flag_word;
    drain();
    write_reg(CFG_BASE_CLOCK, base);
    // upper bits of the flag registers are junk on purpose
    flag_word = $urandom;
    flag_word[0] = v3;
    write_reg(CFG_SPEC_V3, flag_word);
    flag_word = $urandom;
    flag_word[0] = prog;
    write_reg(CFG_PROG_MODE, flag_word);
    base_now = base;
    settings++;
  endtask

  task automatic send_item(input logic [DATA_W-1:0] val, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    target_hz <= val;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    logic [DATA_W-1:0] base;
    logic v3, prog;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (div3_targets[i]) send_item(div3_targets[i], pick_gap());
    configure(BASE_CLOCK_RST, 1'b1, 1'b1);
    foreach (prog_targets[i]) send_item(prog_targets[i], pick_gap());
    configure(BASE_CLOCK_RST, 1'b0, 1'b1);
    foreach (pow2_targets[i]) send_item(pow2_targets[i], pick_gap());
    configure('0, 1'b1, 1'b0);
    foreach (zero_targets[i]) send_item(zero_targets[i], pick_gap());

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case ($urandom_range(0, 3))
        0:       base = $urandom;
        1:       base = $urandom_range(1, 5000);
        2:       base = $urandom_range(25_000_000, 400_000_000);
        default: base = BASE_CLOCK_RST;
      endcase
      v3   = ($urandom_range(0, 3) != 0);
      prog = $urandom_range(0, 1);
      if (k == 0) begin
        base = '1;
        v3   = 1'b1;
        prog = 1'b1;
      end else if (k == 1) begin
        base = 32'd1;
        v3   = 1'b0;
      end
      configure(base, v3, prog);
      if (k == 2) write_reg(CFG_SPARE, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) drain();
        send_item(random_target(base_now), pick_gap());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests over %0d register settings in divided, programmable",
             sent, settings);
    $display("and power-of-two modes; %0d results checked, %0d of them clamped.",
             checked, clamp_hits);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/sdcds_pkg.sv
src/sd_host_clock_divisor_select_unit.sv
verif/sd_clock_divisor_checker.sv
verif/testbench.sv
